/* rtl/sfma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_pkg
// Shared types and constants of the sensor frame moving average block.
// ----------------------------------------------------------------------------
package sfma_pkg;

    // Window length and queue depth defaults
    localparam int DEFAULT_TAPS        = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    // Field widths
    localparam int ID_W     = 11;
    localparam int LEN_W    = 4;
    localparam int OLEN_W   = 2;
    localparam int SAMPLE_W = 16;
    localparam int CHANNELS = 4;
    localparam int CHAN_W   = 2;

    // Incoming frame identifiers and lengths
    localparam logic [ID_W-1:0]  ID_LIGHT_IN = 11'h010;
    localparam logic [ID_W-1:0]  ID_REAR_IN  = 11'h012;
    localparam logic [ID_W-1:0]  ID_TEMP_IN  = 11'h014;
    localparam logic [ID_W-1:0]  ID_FRONT_IN = 11'h020;
    localparam logic [LEN_W-1:0] LEN_LIGHT   = 4'd6;
    localparam logic [LEN_W-1:0] LEN_TEMP    = 4'd1;
    localparam logic [LEN_W-1:0] LEN_DIST    = 4'd2;

    // Outgoing frame identifiers and lengths
    localparam logic [ID_W-1:0]   ID_LIGHT_OUT = 11'h031;
    localparam logic [ID_W-1:0]   ID_TEMP_OUT  = 11'h033;
    localparam logic [ID_W-1:0]   ID_FRONT_OUT = 11'h035;
    localparam logic [ID_W-1:0]   ID_REAR_OUT  = 11'h037;
    localparam logic [ID_W-1:0]   ID_SPEED_OUT = 11'h015;
    localparam logic [OLEN_W-1:0] OLEN_ONE     = 2'd1;
    localparam logic [OLEN_W-1:0] OLEN_TWO     = 2'd2;

    // Configuration and speed counter
    localparam logic [SAMPLE_W-1:0] DIST_MAX_RESET = 16'd300;
    localparam logic [7:0]          SPEED_STEP     = 8'd5;
    localparam logic [7:0]          SPEED_TOP      = 8'd140;

    // Divide by 3 of a sum of three 16-bit readings: exact reciprocal multiply
    localparam int                    LIGHT_SUM_W = 18;
    localparam int                    DIV3_SHIFT  = 20;
    localparam int                    DIV3_MULT_W = 19;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT  = 19'd349526;

    typedef enum logic [CHAN_W-1:0] {
        CH_LIGHT = 2'd0,
        CH_TEMP  = 2'd1,
        CH_FRONT = 2'd2,
        CH_REAR  = 2'd3
    } t_chan;

    typedef struct packed {
        t_chan               chan;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage

/* rtl/sfma_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfma_ram #(
    parameter int WIDTH = sfma_pkg::SAMPLE_W,
    parameter int DEPTH = sfma_pkg::CHANNELS * sfma_pkg::DEFAULT_TAPS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sfma_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_front
// Frame decode: checks id and length, repairs distance readings, averages
// the three light readings, and pushes one sample word into the queue.
// ----------------------------------------------------------------------------
module sfma_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sfma_pkg::ID_W-1:0]           i_frame_id,
    input  logic [sfma_pkg::LEN_W-1:0]          i_frame_length,
    input  logic [7:0]                          i_byte0,
    input  logic [7:0]                          i_byte1,
    input  logic [7:0]                          i_byte2,
    input  logic [7:0]                          i_byte3,
    input  logic [7:0]                          i_byte4,
    input  logic [7:0]                          i_byte5,
    input  logic [sfma_pkg::SAMPLE_W-1:0]       i_dist_max,
    input  logic                                i_full,
    output sfma_pkg::t_push                     o_push
);

    localparam int VW = sfma_pkg::LIGHT_SUM_W;
    localparam int PW = VW + sfma_pkg::DIV3_MULT_W;

    logic                          r_f1_valid;
    sfma_pkg::t_chan               r_f1_chan;
    logic [VW-1:0]                 r_f1_value;
    logic [sfma_pkg::SAMPLE_W-1:0] r_front_good;
    logic [sfma_pkg::SAMPLE_W-1:0] r_rear_good;

    logic [sfma_pkg::SAMPLE_W-1:0] w_r0, w_r1, w_r2, w_dist, w_good, w_fixed;
    logic [VW-1:0]                 w_sum3;
    logic                          w_is_front, w_is_rear, w_kind_ok;
    sfma_pkg::t_chan               w_chan;
    logic [VW-1:0]                 w_value;
    logic                          w_advance, w_accept;
    logic [PW-1:0]                 w_prod;

    always_comb begin
        w_r0       = {i_byte1, i_byte0};
        w_r1       = {i_byte3, i_byte2};
        w_r2       = {i_byte5, i_byte4};
        w_sum3     = VW'(w_r0) + VW'(w_r1) + VW'(w_r2);
        w_dist     = {i_byte1, i_byte0};
        w_is_front = (i_frame_id == sfma_pkg::ID_FRONT_IN);
        w_is_rear  = (i_frame_id == sfma_pkg::ID_REAR_IN);
        w_good     = w_is_front ? r_front_good : r_rear_good;
        // zero or out-of-range reading: reuse the last good one
        w_fixed    = (w_dist == '0 || w_dist > i_dist_max) ? w_good : w_dist;

        w_kind_ok = 1'b0;
        w_chan    = sfma_pkg::CH_LIGHT;
        w_value   = '0;
        if (i_frame_id == sfma_pkg::ID_LIGHT_IN) begin
            w_kind_ok = (i_frame_length == sfma_pkg::LEN_LIGHT);
            w_chan    = sfma_pkg::CH_LIGHT;
            w_value   = w_sum3;
        end else if (i_frame_id == sfma_pkg::ID_TEMP_IN) begin
            w_kind_ok = (i_frame_length == sfma_pkg::LEN_TEMP);
            w_chan    = sfma_pkg::CH_TEMP;
            w_value   = VW'(i_byte0);
        end else if (w_is_front || w_is_rear) begin
            w_kind_ok = (i_frame_length == sfma_pkg::LEN_DIST);
            w_chan    = w_is_front ? sfma_pkg::CH_FRONT : sfma_pkg::CH_REAR;
            w_value   = VW'(w_fixed);
        end
    end

    assign w_advance  = !r_f1_valid || !i_full;
    assign o_in_stall = !w_advance;
    assign w_accept   = i_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid   <= 1'b0;
            r_front_good <= '0;
            r_rear_good  <= '0;
        end else begin
            if (w_advance) begin
                // drop unknown ids and wrong lengths here
                r_f1_valid <= w_accept && w_kind_ok;
            end
            if (w_accept && w_kind_ok && w_is_front) begin
                r_front_good <= w_fixed;
            end
            if (w_accept && w_kind_ok && w_is_rear) begin
                r_rear_good <= w_fixed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_chan  <= w_chan;
            r_f1_value <= w_value;
        end
    end

    assign w_prod = PW'(r_f1_value) * PW'(sfma_pkg::DIV3_MULT);

    always_comb begin
        o_push.valid     = r_f1_valid && !i_full;
        o_push.item.chan = r_f1_chan;
        if (r_f1_chan == sfma_pkg::CH_LIGHT) begin
            o_push.item.sample = w_prod[sfma_pkg::DIV3_SHIFT +: sfma_pkg::SAMPLE_W];
        end else begin
            o_push.item.sample = r_f1_value[sfma_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

/* rtl/sfma_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_fifo
// Short queue of sample words between frame decode and the filter engine.
// ----------------------------------------------------------------------------
module sfma_fifo #(
    parameter int DEPTH = sfma_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfma_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sfma_pkg::t_item o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sfma_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push.valid && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

/* rtl/sfma_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_back
// Filter engine: updates the window of each channel and its running sum,
// divides the sum by the window length and formats the result frames.
// ----------------------------------------------------------------------------
module sfma_back #(
    parameter int TAPS = sfma_pkg::DEFAULT_TAPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  sfma_pkg::t_item               i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sfma_pkg::ID_W-1:0]     o_out_id,
    output logic [sfma_pkg::OLEN_W-1:0]   o_out_length,
    output logic [7:0]                    o_out_low,
    output logic [7:0]                    o_out_high,
    output logic                          o_last
);

    localparam int POS_W  = $clog2(TAPS);
    localparam int ADDR_W = sfma_pkg::CHAN_W + POS_W;
    localparam int DEPTH  = sfma_pkg::CHANNELS << POS_W;
    localparam int SUM_W  = sfma_pkg::SAMPLE_W + POS_W;
    // floor(sum / TAPS) = (sum * RECIP) >> SHIFT, exact for every sum < 2**SUM_W
    localparam int SHIFT  = SUM_W + POS_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) + TAPS - 1) / TAPS);
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(TAPS - 1);

    logic [POS_W-1:0]              r_pos [sfma_pkg::CHANNELS];
    logic [SUM_W-1:0]              r_sum [sfma_pkg::CHANNELS];
    logic [DEPTH-1:0]              r_vld;
    logic [7:0]                    r_speed;

    logic                          r_a_valid;
    sfma_pkg::t_item               r_a_item;
    logic [ADDR_W-1:0]             r_a_addr;
    logic                          r_a_hit;

    logic                          r_c_valid;
    sfma_pkg::t_chan               r_c_chan;
    logic [SUM_W-1:0]              r_c_sum;
    logic                          r_c_phase;

    logic                          r_out_valid;
    logic [sfma_pkg::ID_W-1:0]     r_out_id;
    logic [sfma_pkg::OLEN_W-1:0]   r_out_len;
    logic [7:0]                    r_out_low;
    logic [7:0]                    r_out_high;
    logic                          r_out_last;

    logic [ADDR_W-1:0]             w_raddr;
    logic [sfma_pkg::SAMPLE_W-1:0] w_rdata, w_old;
    logic [SUM_W-1:0]              w_new_sum;
    logic                          w_out_ok, w_c_done, w_a_move;
    logic [PROD_W-1:0]             w_prod;
    logic [sfma_pkg::SAMPLE_W-1:0] w_avg;
    logic [7:0]                    w_speed_inc, w_speed_next;

    assign w_out_ok = !r_out_valid || !i_out_stall;
    // temperature holds this stage for a second word (the speed frame)
    assign w_c_done = r_c_valid && w_out_ok &&
                      (r_c_chan != sfma_pkg::CH_TEMP || r_c_phase);
    assign w_a_move = r_a_valid && (!r_c_valid || w_c_done);
    assign o_pop    = !i_empty && (!r_a_valid || w_a_move);
    assign w_raddr  = {i_head.chan, r_pos[i_head.chan]};

    sfma_ram #(
        .WIDTH (sfma_pkg::SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_a_move),
        .i_waddr (r_a_addr),
        .i_wdata (r_a_item.sample),
        .i_re    (o_pop),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // never-written window entries read as zero
    assign w_old     = r_a_hit ? w_rdata : '0;
    assign w_new_sum = r_sum[r_a_item.chan] - SUM_W'(w_old) + SUM_W'(r_a_item.sample);

    assign w_prod = PROD_W'(r_c_sum) * PROD_W'(RECIP);
    assign w_avg  = w_prod[SHIFT +: sfma_pkg::SAMPLE_W];

    assign w_speed_inc  = r_speed + sfma_pkg::SPEED_STEP;
    assign w_speed_next = (w_speed_inc > sfma_pkg::SPEED_TOP) ? '0 : w_speed_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sfma_pkg::CHANNELS; i++) begin
                r_pos[i] <= '0;
                r_sum[i] <= '0;
            end
            r_vld       <= '0;
            r_speed     <= '0;
            r_a_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_c_phase   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos[i_head.chan] <= (r_pos[i_head.chan] == LAST_POS) ?
                                      '0 : r_pos[i_head.chan] + 1'b1;
            end
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end

            if (w_a_move) begin
                r_sum[r_a_item.chan] <= w_new_sum;
                r_vld[r_a_addr]      <= 1'b1;
                r_c_valid            <= 1'b1;
            end else if (w_c_done) begin
                r_c_valid <= 1'b0;
            end

            if (w_c_done) begin
                r_c_phase <= 1'b0;
            end else if (r_c_valid && w_out_ok) begin
                r_c_phase <= 1'b1;
            end

            if (r_c_valid && w_out_ok && r_c_chan == sfma_pkg::CH_TEMP && r_c_phase) begin
                r_speed <= w_speed_next;
            end

            if (w_out_ok) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_item <= i_head;
            r_a_addr <= w_raddr;
            r_a_hit  <= r_vld[w_raddr];
        end
        if (w_a_move) begin
            r_c_chan <= r_a_item.chan;
            r_c_sum  <= w_new_sum;
        end
        if (r_c_valid && w_out_ok) begin
            case (r_c_chan)
                sfma_pkg::CH_LIGHT: begin
                    r_out_id   <= sfma_pkg::ID_LIGHT_OUT;
                    r_out_len  <= sfma_pkg::OLEN_TWO;
                    r_out_low  <= w_avg[7:0];
                    r_out_high <= w_avg[15:8];
                    r_out_last <= 1'b1;
                end
                sfma_pkg::CH_TEMP: begin
                    r_out_len  <= sfma_pkg::OLEN_ONE;
                    r_out_high <= '0;
                    if (r_c_phase) begin
                        r_out_id   <= sfma_pkg::ID_SPEED_OUT;
                        r_out_low  <= w_speed_next;
                        r_out_last <= 1'b1;
                    end else begin
                        r_out_id   <= sfma_pkg::ID_TEMP_OUT;
                        r_out_low  <= w_avg[7:0];
                        r_out_last <= 1'b0;
                    end
                end
                sfma_pkg::CH_FRONT: begin
                    r_out_id   <= sfma_pkg::ID_FRONT_OUT;
                    r_out_len  <= sfma_pkg::OLEN_TWO;
                    r_out_low  <= w_avg[7:0];
                    r_out_high <= w_avg[15:8];
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_id   <= sfma_pkg::ID_REAR_OUT;
                    r_out_len  <= sfma_pkg::OLEN_TWO;
                    r_out_low  <= w_avg[7:0];
                    r_out_high <= w_avg[15:8];
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_id     = r_out_id;
    assign o_out_length = r_out_len;
    assign o_out_low    = r_out_low;
    assign o_out_high   = r_out_high;
    assign o_last       = r_out_last;

endmodule

/* rtl/sensor_frame_moving_average.sv */
`timescale 1ns / 1ps
// Path: an accepted frame is registered in the decode stage, written into the queue, then read
// into the window stage, moved to the sum stage and formatted into the output register.
// Throughput: one frame per cycle unless the output stalls or a temperature frame holds the
// filter engine; a temperature frame sends two words in turn through its single output register.
// Reset: synchronous, active low; clears windows (per-entry valid bits), sums, positions,
// last good distances and the speed counter at once, and sets distance_max to 300.
// ----------------------------------------------------------------------------
// sensor_frame_moving_average
// Per-channel moving average of received sensor frames, emitted as packed frames.
// ----------------------------------------------------------------------------
module sensor_frame_moving_average #(
    parameter int TAPS        = sfma_pkg::DEFAULT_TAPS,
    parameter int QUEUE_DEPTH = sfma_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfma_pkg::SAMPLE_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sfma_pkg::ID_W-1:0]     i_frame_id,
    input  logic [sfma_pkg::LEN_W-1:0]    i_frame_length,
    input  logic [7:0]                    i_byte0,
    input  logic [7:0]                    i_byte1,
    input  logic [7:0]                    i_byte2,
    input  logic [7:0]                    i_byte3,
    input  logic [7:0]                    i_byte4,
    input  logic [7:0]                    i_byte5,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sfma_pkg::ID_W-1:0]     o_out_id,
    output logic [sfma_pkg::OLEN_W-1:0]   o_out_length,
    output logic [7:0]                    o_out_low,
    output logic [7:0]                    o_out_high,
    output logic                          o_last
);

    logic [sfma_pkg::SAMPLE_W-1:0] r_dist_max;
    sfma_pkg::t_push               w_push;
    sfma_pkg::t_item               w_head;
    logic                          w_full, w_empty, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_max <= sfma_pkg::DIST_MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dist_max <= i_cfg_data;
        end
    end

    sfma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_id     (i_frame_id),
        .i_frame_length (i_frame_length),
        .i_byte0        (i_byte0),
        .i_byte1        (i_byte1),
        .i_byte2        (i_byte2),
        .i_byte3        (i_byte3),
        .i_byte4        (i_byte4),
        .i_byte5        (i_byte5),
        .i_dist_max     (r_dist_max),
        .i_full         (w_full),
        .o_push         (w_push)
    );

    sfma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sfma_back #(
        .TAPS (TAPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_id     (o_out_id),
        .o_out_length (o_out_length),
        .o_out_low    (o_out_low),
        .o_out_high   (o_out_high),
        .o_last       (o_last)
    );

endmodule

/* rtl/sfma_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sfma_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [sfma_pkg::ID_W-1:0]     o_out_id,
    input logic [sfma_pkg::OLEN_W-1:0]   o_out_length,
    input logic [7:0]                    o_out_low,
    input logic [7:0]                    o_out_high,
    input logic                          o_last
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_id) &&
        $stable(o_out_length) && $stable(o_out_low) && $stable(o_out_high) &&
        $stable(o_last))
        else $error("result word changed while stalled");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one-byte frames carry a zero high byte
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_length != sfma_pkg::OLEN_TWO |->
        o_out_length == sfma_pkg::OLEN_ONE && o_out_high == 8'd0)
        else $error("bad length or high byte");

    // only a temperature word is followed by another word of the same frame
    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_out_id == sfma_pkg::ID_TEMP_OUT)
        else $error("non-final word with wrong id");

    // the speed word follows its temperature word directly, within range
    a_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
        o_out_valid && o_out_id == sfma_pkg::ID_SPEED_OUT && o_last &&
        o_out_low <= sfma_pkg::SPEED_TOP)
        else $error("speed word missing or out of range");

endmodule

bind sensor_frame_moving_average sfma_checker u_sfma_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_id     (o_out_id),
    .o_out_length (o_out_length),
    .o_out_low    (o_out_low),
    .o_out_high   (o_out_high),
    .o_last       (o_last)
);
